// ===== src/lfpd_pkg.sv =====
// Package: shared types, widths and register codes for the line follower PID drive.
`timescale 1ns / 1ps

package lfpd_pkg;

   // Widths of the fixed fields
   localparam int SENSOR_WIDTH = 5;
   localparam int ERROR_WIDTH  = 4;
   localparam int GAIN_WIDTH   = 8;
   localparam int DRIVE_WIDTH  = 8;
   localparam int CSR_INDEX_WIDTH = 2;

   // Integral accumulator and derived datapath widths
   localparam int SUM_WIDTH      = 16;
   // widest product is an unsigned gain (as signed, GAIN_WIDTH+1) times the sum,
   // then two more terms are added
   localparam int PID_WIDTH      = SUM_WIDTH + GAIN_WIDTH + 3;
   localparam int MIX_WIDTH      = PID_WIDTH + 1;

   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
   localparam logic [DRIVE_WIDTH-1:0] DRIVE_MAX = {DRIVE_WIDTH{1'b1}};

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_GAIN_P     = 2'd0,
      CSR_GAIN_I     = 2'd1,
      CSR_GAIN_D     = 2'd2,
      CSR_BASE_SPEED = 2'd3
   } csr_index_type;

   // Sensor patterns that map to a known position
   localparam logic [SENSOR_WIDTH-1:0] PAT_POS4 = 5'h10;
   localparam logic [SENSOR_WIDTH-1:0] PAT_POS3 = 5'h18;
   localparam logic [SENSOR_WIDTH-1:0] PAT_POS2 = 5'h08;
   localparam logic [SENSOR_WIDTH-1:0] PAT_POS1 = 5'h0C;
   localparam logic [SENSOR_WIDTH-1:0] PAT_MID  = 5'h04;
   localparam logic [SENSOR_WIDTH-1:0] PAT_NEG1 = 5'h06;
   localparam logic [SENSOR_WIDTH-1:0] PAT_NEG2 = 5'h02;
   localparam logic [SENSOR_WIDTH-1:0] PAT_NEG3 = 5'h03;
   localparam logic [SENSOR_WIDTH-1:0] PAT_NEG4 = 5'h01;

   // Gains and base speed as one bundle
   typedef struct packed {
      logic [GAIN_WIDTH-1:0] gain_p;
      logic [GAIN_WIDTH-1:0] gain_i;
      logic [GAIN_WIDTH-1:0] gain_d;
      logic [GAIN_WIDTH-1:0] base_speed;
   } cfg_type;

   // Decoded sensor pattern
   typedef struct packed {
      logic                          found;
      logic signed [ERROR_WIDTH-1:0] error;
   } decode_type;

   // Result of one PID step
   typedef struct packed {
      logic [DRIVE_WIDTH-1:0]        left_drive;
      logic [DRIVE_WIDTH-1:0]        right_drive;
      logic signed [ERROR_WIDTH-1:0] position_error;
   } drive_type;

endpackage

// ===== src/lfpd_decode.sv =====
// Sensor pattern decoder: five line-sensor bits to a signed position error.
`timescale 1ns / 1ps

module lfpd_decode (
   input  logic [lfpd_pkg::SENSOR_WIDTH-1:0] sensor_bits,
   output lfpd_pkg::decode_type              decoded
);

   // Nine known patterns; everything else (including no line) is not found
   always_comb begin
      decoded.found = 1'b1;
      case (sensor_bits)
         lfpd_pkg::PAT_POS4: decoded.error = 4'sd4;
         lfpd_pkg::PAT_POS3: decoded.error = 4'sd3;
         lfpd_pkg::PAT_POS2: decoded.error = 4'sd2;
         lfpd_pkg::PAT_POS1: decoded.error = 4'sd1;
         lfpd_pkg::PAT_MID:  decoded.error = 4'sd0;
         lfpd_pkg::PAT_NEG1: decoded.error = -4'sd1;
         lfpd_pkg::PAT_NEG2: decoded.error = -4'sd2;
         lfpd_pkg::PAT_NEG3: decoded.error = -4'sd3;
         lfpd_pkg::PAT_NEG4: decoded.error = -4'sd4;
         default: begin
            decoded.found = 1'b0;
            decoded.error = 4'sd0;
         end
      endcase
   end

endmodule

// ===== src/lfpd_pid_core.sv =====
// PID step: held error and integral state, correction, and clamped motor drives.
`timescale 1ns / 1ps

module lfpd_pid_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  lfpd_pkg::decode_type decoded,
   input  lfpd_pkg::cfg_type    cfg,
   output lfpd_pkg::drive_type  drive
);

   localparam int SW = lfpd_pkg::SUM_WIDTH;
   localparam int PW = lfpd_pkg::PID_WIDTH;
   localparam int MW = lfpd_pkg::MIX_WIDTH;
   localparam int EW = lfpd_pkg::ERROR_WIDTH;
   localparam int DW = lfpd_pkg::DRIVE_WIDTH;

   logic signed [EW-1:0] held_error_ff;
   logic signed [EW-1:0] held_error_in;
   logic signed [SW-1:0] error_sum_ff;
   logic signed [SW-1:0] error_sum_in;

   logic signed [EW-1:0] err;
   logic signed [EW:0]   err_diff;
   logic signed [SW:0]   sum_wide;
   logic signed [SW-1:0] sum_sat;
   logic signed [PW-1:0] p_term;
   logic signed [PW-1:0] i_term;
   logic signed [PW-1:0] d_term;
   logic signed [PW-1:0] pid;
   logic signed [MW-1:0] base_ext;
   logic signed [MW-1:0] left_raw;
   logic signed [MW-1:0] right_raw;

   // Unknown or empty pattern keeps the last error
   assign err      = decoded.found ? decoded.error : held_error_ff;
   assign err_diff = (EW+1)'(err) - (EW+1)'(held_error_ff);

   // Integral with saturation at the signed accumulator limits
   assign sum_wide = (SW+1)'(error_sum_ff) + (SW+1)'(err);
   always_comb begin
      if (sum_wide[SW] != sum_wide[SW-1]) begin
         sum_sat = sum_wide[SW] ? lfpd_pkg::SUM_MIN : lfpd_pkg::SUM_MAX;
      end else begin
         sum_sat = sum_wide[SW-1:0];
      end
   end

   // Three gain products summed into the correction
   assign p_term = PW'($signed({1'b0, cfg.gain_p})) * PW'(err);
   assign i_term = PW'($signed({1'b0, cfg.gain_i})) * PW'(sum_sat);
   assign d_term = PW'($signed({1'b0, cfg.gain_d})) * PW'(err_diff);
   assign pid    = p_term + i_term + d_term;

   assign base_ext  = MW'($signed({1'b0, cfg.base_speed}));
   assign left_raw  = base_ext - MW'(pid);
   assign right_raw = base_ext + MW'(pid);

   // Clamp each side to the drive range
   always_comb begin
      if (left_raw < 0) begin
         drive.left_drive = '0;
      end else if (left_raw > MW'(lfpd_pkg::DRIVE_MAX)) begin
         drive.left_drive = lfpd_pkg::DRIVE_MAX;
      end else begin
         drive.left_drive = left_raw[DW-1:0];
      end
      if (right_raw < 0) begin
         drive.right_drive = '0;
      end else if (right_raw > MW'(lfpd_pkg::DRIVE_MAX)) begin
         drive.right_drive = lfpd_pkg::DRIVE_MAX;
      end else begin
         drive.right_drive = right_raw[DW-1:0];
      end
      drive.position_error = err;
   end

   // State advances once per processed transaction
   always_comb begin
      held_error_in = held_error_ff;
      error_sum_in  = error_sum_ff;
      if (step_en) begin
         held_error_in = err;
         error_sum_in  = sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_error_ff <= '0;
         error_sum_ff  <= '0;
      end else begin
         held_error_ff <= held_error_in;
         error_sum_ff  <= error_sum_in;
      end
   end

endmodule

// ===== src/line_follower_pid_drive.sv =====
// Top level: line follower PID drive with sensor input, CSR port and drive result channel.
`timescale 1ns / 1ps

// Takes one five-bit line-sensor sample per transaction and returns one result per
// sample: left and right motor drive (base speed minus / plus the PID correction,
// clamped to 0..255) and the decoded position error. A new sample is accepted every
// clock cycle while req_stall is low. It passes an input register, then a result
// register; the pattern decode, the saturating integral update and the three gain
// multiplies lie between them and set the clock period. Gains and base speed are
// written through csr_we/csr_index/csr_wdata by the user only while no transaction is
// in flight (not enforced by the block); held error and integral sum clear on reset.
module line_follower_pid_drive (
   input  logic                                clock,
   input  logic                                reset,
   // sensor samples
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lfpd_pkg::SENSOR_WIDTH-1:0]   req_sensor_bits,
   // drive results
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lfpd_pkg::DRIVE_WIDTH-1:0]    rsp_left_drive,
   output logic [lfpd_pkg::DRIVE_WIDTH-1:0]    rsp_right_drive,
   output logic signed [lfpd_pkg::ERROR_WIDTH-1:0] rsp_position_error,
   // configuration writes
   input  logic                                csr_we,
   input  logic [lfpd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [lfpd_pkg::GAIN_WIDTH-1:0]     csr_wdata
);

   logic                              in_valid_ff;
   logic                              in_valid_in;
   logic [lfpd_pkg::SENSOR_WIDTH-1:0] in_bits_ff;
   logic [lfpd_pkg::SENSOR_WIDTH-1:0] in_bits_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   lfpd_pkg::drive_type               rsp_data_ff;
   lfpd_pkg::drive_type               rsp_data_in;
   lfpd_pkg::cfg_type                 cfg_ff;
   lfpd_pkg::cfg_type                 cfg_in;

   lfpd_pkg::decode_type              decoded;
   lfpd_pkg::drive_type               step_drive;
   logic                              advance;

   // Move the input stage into the result register when it is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   lfpd_decode u_decode (
      .sensor_bits (in_bits_ff),
      .decoded     (decoded)
   );

   lfpd_pid_core u_pid_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .decoded (decoded),
      .cfg     (cfg_ff),
      .drive   (step_drive)
   );

   // Pipeline next values
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_bits_in   = in_bits_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_bits_in  = req_sensor_bits;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_drive;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (lfpd_pkg::csr_index_type'(csr_index))
            lfpd_pkg::CSR_GAIN_P:     cfg_in.gain_p     = csr_wdata;
            lfpd_pkg::CSR_GAIN_I:     cfg_in.gain_i     = csr_wdata;
            lfpd_pkg::CSR_GAIN_D:     cfg_in.gain_d     = csr_wdata;
            lfpd_pkg::CSR_BASE_SPEED: cfg_in.base_speed = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_bits_ff  <= in_bits_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_drive     = rsp_data_ff.left_drive;
   assign rsp_right_drive    = rsp_data_ff.right_drive;
   assign rsp_position_error = rsp_data_ff.position_error;

endmodule

// ===== src/lfpd_checker.sv =====
// Port-level checker for the line follower PID drive, bound to the top level.
`timescale 1ns / 1ps

module lfpd_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_stall,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic [lfpd_pkg::DRIVE_WIDTH-1:0]        rsp_left_drive,
   input logic [lfpd_pkg::DRIVE_WIDTH-1:0]        rsp_right_drive,
   input logic signed [lfpd_pkg::ERROR_WIDTH-1:0] rsp_position_error
);

   // A held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_drive)
         && $stable(rsp_right_drive) && $stable(rsp_position_error))
      else $error("result changed while stalled");

   // Reported error stays within the decoded range
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_position_error >= -4'sd4 && rsp_position_error <= 4'sd4))
      else $error("position error out of range");

   // Input is never stalled while the result side is empty
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

   // No result directly after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An accepted transaction with a free result side reaches the result register after the input register
   a_progress: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> ##1 rsp_valid || $past(reset))
      else $error("accepted transaction produced no result");

endmodule

bind line_follower_pid_drive lfpd_checker u_lfpd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_left_drive     (rsp_left_drive),
   .rsp_right_drive    (rsp_right_drive),
   .rsp_position_error (rsp_position_error)
);
